FILE: design/tdds_pkg.sv
// ----------------------------------------------------------------------------
// Tile dedup package
// Sizes, symmetry codes and class codes shared by the dedup unit.
// ----------------------------------------------------------------------------
package tdds_pkg;
  localparam int TileSide   = 16;
  localparam int MaxEntries = 64;
  localparam int RowW       = 16;
  localparam int RowCntW    = $clog2(TileSide + 1);
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int NumSym     = 8;

  typedef logic [TileSide-1:0] row_t;
  typedef row_t [TileSide-1:0] tile_t;

  localparam logic [2:0] SYM_ID   = 3'd0;
  localparam logic [2:0] SYM_LR   = 3'd1;
  localparam logic [2:0] SYM_TB   = 3'd2;
  localparam logic [2:0] SYM_R180 = 3'd3;
  localparam logic [2:0] SYM_R90  = 3'd6;

  localparam logic [2:0] CLS_FULL  = 3'd0;
  localparam logic [2:0] CLS_R90   = 3'd1;
  localparam logic [2:0] CLS_R180M = 3'd2;
  localparam logic [2:0] CLS_R180  = 3'd3;
  localparam logic [2:0] CLS_LR    = 3'd4;
  localparam logic [2:0] CLS_TB    = 3'd5;
  localparam logic [2:0] CLS_NONE  = 3'd6;

  // Pure wiring: dst[y][x] = src[sy][sx] under symmetry code t.
  function automatic tile_t make_variant(tile_t src, logic [2:0] t);
    tile_t d;
    int sy;
    int sx;
    for (int y = 0; y < TileSide; y++) begin
      for (int x = 0; x < TileSide; x++) begin
        sy = t[2] ? x : y;
        sx = t[2] ? y : x;
        if (t[1]) sy = TileSide - 1 - sy;
        if (t[0]) sx = TileSide - 1 - sx;
        d[y][x] = src[sy][sx];
      end
    end
    return d;
  endfunction
endpackage

FILE: design/tdds_row_if.sv
// ----------------------------------------------------------------------------
// Row channel
// Valid/ready channel carrying one tile row per item.
// ----------------------------------------------------------------------------
interface tdds_row_if;
  logic                     valid;
  logic                     ready;
  logic [tdds_pkg::RowW-1:0] tile_row;
  modport source (output valid, output tile_row, input ready);
  modport sink (input valid, input tile_row, output ready);
endinterface

FILE: design/tdds_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one dedup result per item.
// ----------------------------------------------------------------------------
interface tdds_res_if;
  logic       valid;
  logic       ready;
  logic       is_new;
  logic [5:0] entry_index;
  logic [2:0] sym_class;
  logic       table_full;
  modport source (output valid, output is_new, output entry_index, output sym_class,
                  output table_full, input ready);
  modport sink (input valid, input is_new, input entry_index, input sym_class,
                input table_full, output ready);
endinterface

FILE: design/tdds_lane.sv
// ----------------------------------------------------------------------------
// Compare lane
// Compares one symmetry variant of the new tile with a stored entry.
// ----------------------------------------------------------------------------
module tdds_lane (
  input  tdds_pkg::tile_t variant,
  input  tdds_pkg::tile_t stored,
  output logic            hit
);
  assign hit = (variant == stored);
endmodule

FILE: design/tdds_class.sv
// ----------------------------------------------------------------------------
// Symmetry classifier
// Derives the symmetry class of a tile from its own variants.
// ----------------------------------------------------------------------------
module tdds_class (
  input  tdds_pkg::tile_t tile,
  output logic [2:0]      sym_class
);
  logic r90, lr, r180, tb;
  assign r90  = (tdds_pkg::make_variant(tile, tdds_pkg::SYM_R90) == tile);
  assign lr   = (tdds_pkg::make_variant(tile, tdds_pkg::SYM_LR) == tile);
  assign r180 = (tdds_pkg::make_variant(tile, tdds_pkg::SYM_R180) == tile);
  assign tb   = (tdds_pkg::make_variant(tile, tdds_pkg::SYM_TB) == tile);
  always_comb begin
    if (r90 && lr) sym_class = tdds_pkg::CLS_FULL;
    else if (r90) sym_class = tdds_pkg::CLS_R90;
    else if (r180 && lr) sym_class = tdds_pkg::CLS_R180M;
    else if (r180) sym_class = tdds_pkg::CLS_R180;
    else if (lr) sym_class = tdds_pkg::CLS_LR;
    else if (tb) sym_class = tdds_pkg::CLS_TB;
    else sym_class = tdds_pkg::CLS_NONE;
  end
endmodule

FILE: design/tile_dedup_under_dihedral_symmetry_unit.sv
// ----------------------------------------------------------------------------
// Tile dedup under dihedral symmetry
// Collects square binary tiles row by row and deduplicates them against a
// table of stored tiles under the eight rotations and reflections.
// ----------------------------------------------------------------------------
// Channel   Direction  Item
// rows      in         one tile row (tile_row)
// results   out        is_new, entry_index, sym_class, table_full
//
// Each row is taken while the unit is loading. After the last row, the stored
// entries are read from the table memory one per cycle, lowest index first,
// and eight compare lanes test the entry against all eight variants of the
// tile in parallel; the search is sequential because the table memory has a
// single read port. Reset is synchronous and leaves entry 0 as the all-zero
// tile. No row is taken while a tile is being searched or its result waits on
// the output.
module tile_dedup_under_dihedral_symmetry_unit (
  input logic clk,
  input logic rst,
  tdds_row_if.sink   rows,
  tdds_res_if.source results
);
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state;
  logic [tdds_pkg::RowCntW-1:0] row_count;
  logic [tdds_pkg::CntW-1:0] entry_count;
  tdds_pkg::tile_t tile_buffer;
  tdds_pkg::tile_t variants [tdds_pkg::NumSym];
  tdds_pkg::tile_t tile_table [tdds_pkg::MaxEntries];
  tdds_pkg::tile_t rd_data;
  logic rd_zero;
  logic [tdds_pkg::CntW-1:0] rd_addr;
  logic [tdds_pkg::CntW-1:0] cmp_idx;
  logic cmp_valid;
  logic [tdds_pkg::NumSym-1:0] hits;
  logic [2:0] cls;
  logic wr_en;

  tdds_pkg::row_t row_in;
  assign row_in = tdds_pkg::row_t'(rows.tile_row);
  assign rows.ready = (state == ST_LOAD);

  // Variants are wiring from the collected tile.
  for (genvar t = 0; t < tdds_pkg::NumSym; t++) begin : g_var
    assign variants[t] = tdds_pkg::make_variant(tile_buffer, 3'(t));
    tdds_lane u_lane (
      .variant(variants[t]),
      .stored (rd_zero ? '0 : rd_data),
      .hit    (hits[t])
    );
  end

  tdds_class u_class (.tile(tile_buffer), .sym_class(cls));

  // Table memory; entry 0 is the all-zero tile, which is never written to it and whose read data is ignored.
  assign wr_en = (state == ST_DONE) && (entry_count < tdds_pkg::CntW'(tdds_pkg::MaxEntries));
  always_ff @(posedge clk) begin
    if (wr_en) tile_table[entry_count[tdds_pkg::IdxW-1:0]] <= tile_buffer;
    rd_data <= tile_table[rd_addr[tdds_pkg::IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      row_count <= '0;
      entry_count <= tdds_pkg::CntW'(1);
      rd_addr <= '0;
      cmp_valid <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (rows.valid) begin
            tile_buffer[row_count[$clog2(tdds_pkg::TileSide)-1:0]] <= row_in;
            if (row_count == tdds_pkg::RowCntW'(tdds_pkg::TileSide - 1)) begin
              row_count <= '0;
              rd_addr <= '0;
              cmp_valid <= 1'b0;
              state <= ST_SCAN;
            end else begin
              row_count <= row_count + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          // Issue reads; compare the entry read in the previous cycle.
          rd_zero <= (rd_addr == '0);
          cmp_idx <= rd_addr;
          cmp_valid <= (rd_addr < entry_count);
          if (rd_addr < entry_count) rd_addr <= rd_addr + 1'b1;
          if (cmp_valid && (|hits)) begin
            results.valid <= 1'b1;
            results.is_new <= 1'b0;
            results.entry_index <= cmp_idx[5:0];
            results.sym_class <= tdds_pkg::CLS_FULL;
            results.table_full <= 1'b0;
            state <= ST_OUT;
          end else if (cmp_valid && !(rd_addr < entry_count) == 1'b0) begin
            state <= ST_SCAN;
          end else if (!cmp_valid && !(rd_addr < entry_count) && rd_addr != '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          results.valid <= 1'b1;
          results.is_new <= 1'b1;
          results.sym_class <= cls;
          if (wr_en) begin
            results.entry_index <= entry_count[5:0];
            results.table_full <= 1'b0;
            entry_count <= entry_count + 1'b1;
          end else begin
            results.entry_index <= '0;
            results.table_full <= 1'b1;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end
endmodule

FILE: tb/tb_tdds_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile dedup checker
// Watches the row and result channels. It keeps its own tile table, works out
// the result for each completed tile and compares the results field by field.
// ----------------------------------------------------------------------------
module tb_tdds_checker
  import tdds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tdds_row_if        rows,
  tdds_res_if        results,
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic       is_new;
    logic [5:0] entry_index;
    logic [2:0] sym_class;
    logic       table_full;
  } dedup_res_t;

  tile_t      rx_tile;
  int         rx_rows;
  tile_t      known_tiles[$];
  dedup_res_t want_q[$];

  // Pixel (y, x) of the image under code t: bit 2 swaps axes, bit 1 flips
  // rows, bit 0 flips columns.
  function automatic tile_t orient(tile_t src, int t);
    tile_t d;
    int    ry;
    int    rx;
    for (int y = 0; y < TileSide; y++)
      for (int x = 0; x < TileSide; x++) begin
        ry = (t & 4) ? x : y;
        rx = (t & 4) ? y : x;
        if (t & 2) ry = TileSide - 1 - ry;
        if (t & 1) rx = TileSide - 1 - rx;
        d[y][x] = src[ry][rx];
      end
    return d;
  endfunction

  function automatic logic [2:0] classify(tile_t t);
    logic r90;
    logic lr;
    logic r180;
    r90  = orient(t, SYM_R90) == t;
    lr   = orient(t, SYM_LR) == t;
    r180 = orient(t, SYM_R180) == t;
    if (r90 && lr) return CLS_FULL;
    if (r90) return CLS_R90;
    if (r180 && lr) return CLS_R180M;
    if (r180) return CLS_R180;
    if (lr) return CLS_LR;
    if (orient(t, SYM_TB) == t) return CLS_TB;
    return CLS_NONE;
  endfunction

  function automatic dedup_res_t dedup_tile(tile_t t);
    dedup_res_t r;
    r = '0;
    foreach (known_tiles[e])
      for (int s = 0; s < NumSym; s++)
        if (known_tiles[e] == orient(t, s)) begin
          r.entry_index = e[5:0];
          return r;
        end
    r.is_new    = 1'b1;
    r.sym_class = classify(t);
    if (known_tiles.size() >= MaxEntries) begin
      r.table_full = 1'b1;
    end else begin
      r.entry_index = 6'(known_tiles.size());
      known_tiles = {known_tiles, t};
    end
    return r;
  endfunction

  assign pending_count = want_q.size();

  always @(posedge clk) begin
    dedup_res_t got;
    dedup_res_t want;
    if (rst) begin
      rx_rows    <= 0;
      fail_count <= 0;
      known_tiles = {tile_t'('0)};
      want_q.delete();
    end else begin
      if (rows.valid && rows.ready) begin
        rx_tile[rx_rows] = rows.tile_row;
        if (rx_rows == TileSide - 1) begin
          want_q = {want_q, dedup_tile(rx_tile)};
          rx_rows <= 0;
        end else begin
          rx_rows <= rx_rows + 1;
        end
      end
      if (results.valid && results.ready) begin
        got = '{results.is_new, results.entry_index, results.sym_class,
                results.table_full};
        if (want_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: is_new %0d index %0d class %0d full %0d",
                     got.is_new, got.entry_index, got.sym_class, got.table_full);
          fail_count <= fail_count + 1;
        end else begin
          want = want_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: want new %0d idx %0d cls %0d full %0d, got %0d %0d %0d %0d",
                       want.is_new, want.entry_index, want.sym_class, want.table_full,
                       got.is_new, got.entry_index, got.sym_class, got.table_full);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile dedup testbench
// Sends whole tiles row by row: fixed tiles first, then fresh random tiles,
// tiles built to carry each symmetry, and rotated or mirrored copies of
// earlier tiles, enough to fill the table and overflow it. Both channels
// idle at random. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import tdds_pkg::*;

  localparam int NumRandTiles = 67;
  localparam int CycleLimit   = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;
  int   ready_hold  = 0;
  logic burst_mode  = 1'b0;
  tile_t sent_tiles[$];

  tdds_row_if rows ();
  tdds_res_if results ();

  always #2 clk = ~clk;

  tile_dedup_under_dihedral_symmetry_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .rows    (rows.sink),
    .results (results.source)
  );

  tb_tdds_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .rows          (rows),
    .results       (results),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // The run must end even if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: after each accepted item, hold ready low for a random stall.
  // In burst mode ready stays high so back-to-back results are seen.
  always @(posedge clk) begin
    int n;
    if (rst) begin
      results.ready <= 1'b0;
      ready_hold    <= 0;
    end else if (results.valid && results.ready) begin
      n = burst_mode ? 0 : $urandom_range(9);
      ready_hold    <= n;
      results.ready <= (n == 0);
    end else if (ready_hold > 0) begin
      ready_hold    <= ready_hold - 1;
      results.ready <= (ready_hold == 1);
    end else begin
      results.ready <= 1'b1;
    end
  end

  // Same mapping as the checker uses; here it only builds stimulus.
  function automatic tile_t reorient(tile_t src, int t);
    tile_t d;
    for (int y = 0; y < TileSide; y++)
      for (int x = 0; x < TileSide; x++)
        d[y][x] = src[(t & 4) ? ((t & 2) ? TileSide - 1 - x : x)
                              : ((t & 2) ? TileSide - 1 - y : y)]
                     [(t & 4) ? ((t & 1) ? TileSide - 1 - y : y)
                              : ((t & 1) ? TileSide - 1 - x : x)];
    return d;
  endfunction

  // Wait a random gap (none in burst mode), then hold the row until taken.
  task automatic send_row(input row_t r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(9);
    if (gap > 0) begin
      rows.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rows.valid    <= 1'b1;
    rows.tile_row <= r;
    @(posedge clk);
    while (!rows.ready) @(posedge clk);
  endtask

  task automatic send_tile(input tile_t t);
    for (int y = 0; y < TileSide; y++) send_row(t[y]);
    sent_tiles = {sent_tiles, t};
  endtask

  function automatic tile_t noise_tile();
    tile_t t;
    for (int y = 0; y < TileSide; y++) t[y] = row_t'($urandom());
    return t;
  endfunction

  // Symmetrize a random seed by OR-ing it over a set of symmetry codes, so
  // the tile lands in (at least) the wanted class.
  function automatic tile_t symmetric_tile(int kind);
    tile_t seed;
    tile_t t;
    seed = noise_tile();
    // Sparse seeds keep the union from saturating to all ones.
    for (int y = 0; y < TileSide; y++) seed[y] &= row_t'($urandom() & $urandom());
    t = seed;
    case (kind)
      0: for (int s = 1; s < NumSym; s++) t |= reorient(seed, s);
      1: t = seed | reorient(seed, SYM_R90) | reorient(seed, SYM_R180)
             | reorient(reorient(seed, SYM_R90), SYM_R180);
      2: t = seed | reorient(seed, SYM_LR) | reorient(seed, SYM_TB)
             | reorient(seed, SYM_R180);
      3: t = seed | reorient(seed, SYM_R180);
      4: t = seed | reorient(seed, SYM_LR);
      default: t = seed | reorient(seed, SYM_TB);
    endcase
    return t;
  endfunction

  initial begin
    tile_t t;
    int pick;
    int waited;
    rows.valid    = 1'b0;
    rows.tile_row = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: the all-ones tile is new with full symmetry, the all-zero
    // tile matches the entry present from reset.
    send_tile('1);
    send_tile('0);

    // Most tiles are fresh, so the table fills and a few tiles overflow it;
    // every seventeenth tile repeats an earlier tile under some symmetry.
    for (int i = 0; i < NumRandTiles; i++) begin
      burst_mode = ($urandom_range(5) == 0);
      pick = $urandom_range(99);
      if (i % 17 == 16) begin
        if (pick < 90) t = reorient(sent_tiles[$urandom_range(sent_tiles.size() - 1)],
                                    $urandom_range(7));
        else t = '0;
      end else if (pick < 70) begin
        t = noise_tile();
      end else begin
        t = symmetric_tile($urandom_range(5));
      end
      send_tile(t);
    end
    rows.valid <= 1'b0;
    burst_mode = 1'b0;

    // Drain, then allow a search's worth of cycles for stray results.
    waited = 0;
    while (pending_count != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: tile_dedup_under_dihedral_symmetry_unit.f
design/tdds_pkg.sv
design/tdds_row_if.sv
design/tdds_res_if.sv
design/tdds_lane.sv
design/tdds_class.sv
design/tile_dedup_under_dihedral_symmetry_unit.sv
tb/tb_tdds_checker.sv
tb/tb_top.sv
